@@ rtl/clsr_pkg.sv @@
`timescale 1ns / 1ps
package clsr_pkg;

	localparam int VAL_W = 31;

	// first generator: z1 <- 40014 * z1 mod (2^31 - 85)
	localparam logic [15:0] MUL1  = 16'd40014;
	localparam logic [8:0]  FOLD1 = 9'd85;
	localparam logic [31:0] MOD1  = 32'd2147483563;

	// second generator: z2 <- 40692 * z2 mod (2^31 - 249)
	localparam logic [15:0] MUL2  = 16'd40692;
	localparam logic [8:0]  FOLD2 = 9'd249;
	localparam logic [31:0] MOD2  = 32'd2147483399;

	localparam logic [31:0] MOD1_LESS1 = MOD1 - 32'd1;
	localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;
	localparam int WARMUP_EXTRA = 8;

	typedef enum logic {
		CMD_DRAW   = 1'b0,
		CMD_RESEED = 1'b1
	} rng_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_RED,
		ST_DRAW_MUL,
		ST_DRAW_RED,
		ST_DRAW_OUT
	} clsr_state_t;

	typedef struct packed {
		logic load_seed;
		logic mul_en;
		logic upd_z1;
		logic upd_z2;
		logic warm_wr;
		logic warm_last;
		logic read_slot;
		logic commit;
	} clsr_cmd_t;

endpackage

@@ rtl/clsr_if.sv @@
`timescale 1ns / 1ps
interface clsr_req_if import clsr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             command;
	logic [VAL_W-1:0] seed_value;

	modport source (output valid, output command, output seed_value, input ready);
	modport sink (input valid, input command, input seed_value, output ready);
endinterface

interface clsr_rsp_if import clsr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] random_value;

	modport source (output valid, output random_value, input ready);
	modport sink (input valid, input random_value, output ready);
endinterface

@@ rtl/clsr_ram.sv @@
`timescale 1ns / 1ps
module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/clsr_modmul.sv @@
`timescale 1ns / 1ps
module clsr_modmul import clsr_pkg::*; #(
	parameter logic [15:0] MULT    = 16'd40014,
	parameter logic [8:0]  FOLD    = 9'd85,
	parameter logic [31:0] MODULUS = 32'd2147483563
) (
	input  logic             clk,
	input  logic             en,
	input  logic [VAL_W-1:0] z,
	output logic [VAL_W-1:0] r
);

	localparam int PW = VAL_W + 16;

	logic [PW-1:0] prod_q;
	logic [31:0]   sum;
	logic [31:0]   red;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(z) * PW'(MULT);
		end
	end

	// 2^31 is congruent to FOLD: fold the high part down, then one subtract
	always_comb begin
		sum = 32'(prod_q[PW-1:VAL_W]) * 32'(FOLD) + 32'(prod_q[VAL_W-1:0]);
		red = (sum >= MODULUS) ? (sum - MODULUS) : sum;
		r   = red[VAL_W-1:0];
	end

endmodule

@@ rtl/clsr_ctrl.sv @@
`timescale 1ns / 1ps
module clsr_ctrl import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CW = $clog2(TABLE_DEPTH + WARMUP_EXTRA)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_command,
	output logic          req_ready,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output clsr_cmd_t     cmd,
	output logic [IW-1:0] warm_idx
);

	clsr_state_t   state_q;
	clsr_state_t   state_d;
	logic [CW-1:0] cnt_q;
	logic          ovalid_q;
	logic          out_free;
	logic          is_reseed;

	assign out_free  = !ovalid_q || rsp_ready;
	assign rsp_valid = ovalid_q;
	assign warm_idx  = cnt_q[IW-1:0];
	assign is_reseed = req_command == CMD_RESEED;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = is_reseed ? ST_SEED_MUL : ST_DRAW_RED;
				end
			end
			ST_SEED_MUL: state_d = ST_SEED_RED;
			ST_SEED_RED: state_d = (cnt_q == '0) ? ST_DRAW_MUL : ST_SEED_MUL;
			ST_DRAW_MUL: state_d = ST_DRAW_RED;
			ST_DRAW_RED: state_d = ST_DRAW_OUT;
			ST_DRAW_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.load_seed = req_valid && is_reseed;
				cmd.mul_en    = req_valid && !is_reseed;
				cmd.read_slot = req_valid && !is_reseed;
			end
			ST_SEED_MUL: cmd.mul_en = 1'b1;
			ST_SEED_RED: begin
				cmd.upd_z1    = 1'b1;
				cmd.warm_wr   = cnt_q < CW'(TABLE_DEPTH);
				cmd.warm_last = cnt_q == '0;
			end
			ST_DRAW_MUL: begin
				cmd.mul_en    = 1'b1;
				cmd.read_slot = 1'b1;
			end
			ST_DRAW_RED: begin
				cmd.upd_z1 = 1'b1;
				cmd.upd_z2 = 1'b1;
			end
			ST_DRAW_OUT: cmd.commit = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_seed) begin
				cnt_q <= CW'(TABLE_DEPTH + WARMUP_EXTRA - 1);
			end else if (cmd.upd_z1 && state_q == ST_SEED_RED && cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.commit) begin
				ovalid_q <= 1'b1;
			end else if (rsp_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/clsr_dpath.sv @@
`timescale 1ns / 1ps
module clsr_dpath import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = 32,
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  clsr_cmd_t        cmd,
	input  logic [IW-1:0]    warm_idx,
	input  logic [VAL_W-1:0] seed_value,
	output logic [VAL_W-1:0] random_value
);

	localparam logic [31:0] SLOT_DIV = 32'(1 + (MOD1_LESS1 / 32'(TABLE_DEPTH)));

	logic [VAL_W-1:0]     z1_q;
	logic [VAL_W-1:0]     z2_q;
	logic [VAL_W-1:0]     last_q;
	logic [VAL_W-1:0]     rnd_q;
	logic [IW-1:0]        slot_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [VAL_W-1:0]     r1;
	logic [VAL_W-1:0]     r2;
	logic [VAL_W-1:0]     seed_z;
	logic [TABLE_DEPTH:0] ge;
	logic [IW-1:0]        slot_c;
	logic [VAL_W-1:0]     rdata;
	logic [VAL_W-1:0]     entry;
	logic [31:0]          diff;
	logic [31:0]          wrapped;
	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	logic [VAL_W-1:0]     ram_wdata;

	assign seed_z       = (seed_value == '0) ? VAL_W'(1) : seed_value;
	assign random_value = rnd_q;

	clsr_modmul #(.MULT(MUL1), .FOLD(FOLD1), .MODULUS(MOD1)) u_first (
		.clk (clk),
		.en  (cmd.mul_en),
		.z   (z1_q),
		.r   (r1)
	);

	clsr_modmul #(.MULT(MUL2), .FOLD(FOLD2), .MODULUS(MOD2)) u_second (
		.clk (clk),
		.en  (cmd.mul_en),
		.z   (z2_q),
		.r   (r2)
	);

	// slot = last / SLOT_DIV, saturated: thermometer of threshold compares
	always_comb begin
		ge              = '0;
		ge[0]           = 1'b1;
		for (int k = 1; k < TABLE_DEPTH; k++) begin
			ge[k] = {1'b0, last_q} >= (32'(k) * SLOT_DIV);
		end
		slot_c = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (ge[k] && !ge[k+1]) begin
				slot_c = slot_c | IW'(k);
			end
		end
	end

	// an entry never written reads as zero
	always_comb begin
		entry   = valid_q[slot_q] ? rdata : '0;
		diff    = {1'b0, entry} - {1'b0, z2_q};
		wrapped = (diff[31] || diff == '0) ? (diff + MOD1_LESS1) : diff;
	end

	always_comb begin
		ram_we    = cmd.warm_wr || cmd.commit;
		ram_waddr = cmd.warm_wr ? warm_idx : slot_q;
		ram_wdata = cmd.warm_wr ? r1 : z1_q;
	end

	clsr_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read_slot),
		.raddr (slot_c),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q    <= VAL_W'(1);
			z2_q    <= SECOND_RESET;
			last_q  <= '0;
			valid_q <= '0;
		end else begin
			if (cmd.load_seed) begin
				z1_q <= seed_z;
				z2_q <= seed_z;
			end else begin
				if (cmd.upd_z1) begin
					z1_q <= r1;
				end
				if (cmd.upd_z2) begin
					z2_q <= r2;
				end
			end
			if (cmd.warm_last) begin
				last_q <= r1;
			end else if (cmd.commit) begin
				last_q <= wrapped[VAL_W-1:0];
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_slot) begin
			slot_q <= slot_c;
		end
		if (cmd.commit) begin
			rnd_q <= wrapped[VAL_W-1:0];
		end
	end

endmodule

@@ rtl/combined_lcg_shuffle_rng.sv @@
`timescale 1ns / 1ps
// Draw: accept + both products, fold/reduce, then table combine, which waits
// while the last result is still held in the output register and not yet taken.
// Reseed: seed both generators, then TABLE_DEPTH + WARMUP_EXTRA warm-up steps of
// the first generator (a multiply, then a reduce, each), then a draw as above.
// Result appears in the output register the cycle after the combine step.
// Reset: generators to 1 and 123456789, last output to zero, table reads as zero.
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	clsr_req_if.sink    req,
	clsr_rsp_if.source  rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	clsr_cmd_t     cmd;
	logic [IW-1:0] warm_idx;

	clsr_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.cmd         (cmd),
		.warm_idx    (warm_idx)
	);

	clsr_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.warm_idx     (warm_idx),
		.seed_value   (req.seed_value),
		.random_value (rsp.random_value)
	);

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.random_value != '0) && (rsp.random_value <= 31'd2147483562))
		else $error("result out of range");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.warm_wr && cmd.commit))
		else $error("warm-up and draw both write the table");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("committed result not presented");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !cmd.upd_z1 && !cmd.upd_z2 && !cmd.commit)
		else $error("state advanced while idle");

endmodule

@@ tb/sv/tb_combined_lcg_shuffle_rng.sv @@
`timescale 1ns / 1ps
module tb_combined_lcg_shuffle_rng;
	import clsr_pkg::*;

	localparam int DEPTH = 32;
	localparam longint unsigned GEN1_MOD = 64'd2147483563;
	localparam longint unsigned GEN2_MOD = 64'd2147483399;
	localparam longint unsigned GEN1_MUL = 64'd40014;
	localparam longint unsigned GEN2_MUL = 64'd40692;
	localparam longint WRAP = 64'd2147483562;
	localparam longint SLOT_DIV = 64'd1 + WRAP / DEPTH;
	localparam int WARM_STEPS = DEPTH + 8;
	localparam int RANDOM_ITEMS = 850;

	typedef struct {
		rng_cmd_t         cmd;
		logic [VAL_W-1:0] seed;
	} rng_req_t;

	logic clk;
	logic arst_n;

	clsr_req_if req_ch ();
	clsr_rsp_if rsp_ch ();

	combined_lcg_shuffle_rng #(.TABLE_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// predictor state
	logic [VAL_W-1:0] gen1_z;
	logic [VAL_W-1:0] gen2_z;
	logic [VAL_W-1:0] prev_value;
	logic [VAL_W-1:0] shuffle_slots [DEPTH];

	rng_req_t         pending_cmds[$];
	logic [VAL_W-1:0] expected_values[$];

	int errors = 0;
	int issued = 0;
	int idle_pct = 0;
	int src_gap = 0;
	int snk_gap = 0;
	bit req_beat = 1'b0;
	bit calm = 1'b0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [VAL_W-1:0] gen1_next(input logic [VAL_W-1:0] z);
		longint unsigned prod;
		prod = 64'(z) * GEN1_MUL;
		return VAL_W'(prod % GEN1_MOD);
	endfunction

	function automatic logic [VAL_W-1:0] gen2_next(input logic [VAL_W-1:0] z);
		longint unsigned prod;
		prod = 64'(z) * GEN2_MUL;
		return VAL_W'(prod % GEN2_MOD);
	endfunction

	task automatic predict_draw(input rng_cmd_t cmd, input logic [VAL_W-1:0] seed);
		logic [VAL_W-1:0] z;
		longint slot;
		longint diff;
		if (cmd == CMD_RESEED) begin
			z = (seed == '0) ? VAL_W'(1) : seed;
			gen2_z = z;
			for (int i = WARM_STEPS - 1; i >= 0; i--) begin
				z = gen1_next(z);
				if (i < DEPTH)
					shuffle_slots[i] = z;
			end
			gen1_z = z;
			prev_value = shuffle_slots[0];
		end
		gen1_z = gen1_next(gen1_z);
		gen2_z = gen2_next(gen2_z);
		slot = longint'(prev_value) / SLOT_DIV;
		if (slot >= DEPTH)
			slot = DEPTH - 1;
		diff = longint'(shuffle_slots[slot]) - longint'(gen2_z);
		shuffle_slots[slot] = gen1_z;
		if (diff < 1)
			diff += WRAP;
		prev_value = diff[VAL_W-1:0];
		expected_values.push_back(prev_value);
	endtask

	task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		errors++;
		$display("ERROR %0t: %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	task automatic queue_cmd(input rng_cmd_t cmd, input logic [VAL_W-1:0] seed);
		rng_req_t item;
		item.cmd = cmd;
		item.seed = seed;
		pending_cmds.push_back(item);
	endtask

	function automatic logic [VAL_W-1:0] pick_seed();
		logic [VAL_W-1:0] odd_seeds [7];
		odd_seeds = '{31'd0, 31'd1, 31'd2147483399, 31'd2147483563, 31'd2147483562,
			31'd2147483564, 31'h7fffffff};
		if ($urandom_range(7) == 0)
			return odd_seeds[$urandom_range(6)];
		return VAL_W'($urandom);
	endfunction

	// sample both channels, predict and check
	always @(posedge clk) begin
		calm = pending_cmds.size() < 80;
		req_beat = arst_n && req_ch.valid && req_ch.ready;
		if (req_beat)
			predict_draw(rng_cmd_t'(req_ch.command), req_ch.seed_value);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_values.size() == 0)
				report_mismatch("result with nothing pending", rsp_ch.random_value, '0);
			else if (rsp_ch.random_value !== expected_values[0]) begin
				report_mismatch("random_value", rsp_ch.random_value, expected_values[0]);
				void'(expected_values.pop_front());
			end else
				void'(expected_values.pop_front());
		end
	end

	// request driver
	always @(negedge clk) begin
		rng_req_t item;
		if (arst_n) begin
			if (req_ch.valid && !req_beat) begin
				// hold the beat until taken
			end else if (src_gap > 0) begin
				src_gap--;
				req_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0 && !calm && $urandom_range(99) < idle_pct) begin
				src_gap = $urandom_range(3);
				req_ch.valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				item = pending_cmds.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.command <= item.cmd;
				req_ch.seed_value <= item.seed;
				issued++;
				if (issued % 48 == 0)
					idle_pct = $urandom_range(2) * 22;
			end else
				req_ch.valid <= 1'b0;
		end
	end

	// response backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				snk_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(99) < idle_pct) begin
				snk_gap = $urandom_range(3);
				rsp_ch.ready <= 1'b0;
			end else
				rsp_ch.ready <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL combined_lcg_shuffle_rng");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_DRAW;
		req_ch.seed_value = '0;
		rsp_ch.ready = 1'b0;
		gen1_z = VAL_W'(1);
		gen2_z = SECOND_RESET;
		prev_value = '0;
		foreach (shuffle_slots[i])
			shuffle_slots[i] = '0;

		// draws straight out of reset run on an all-zero table
		queue_cmd(CMD_DRAW, 31'h7fffffff);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_DRAW, 31'h2aaaaaaa);
		queue_cmd(CMD_RESEED, '0);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_RESEED, 31'd1);
		queue_cmd(CMD_DRAW, 31'h55555555);
		queue_cmd(CMD_RESEED, 31'h7fffffff);
		queue_cmd(CMD_DRAW, '0);
		// first generator collapses to zero and stays there
		queue_cmd(CMD_RESEED, 31'd2147483563);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_DRAW, '0);
		// second generator collapses to zero
		queue_cmd(CMD_RESEED, 31'd2147483399);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_RESEED, 31'd2147483562);
		queue_cmd(CMD_RESEED, 31'd2147483564);
		queue_cmd(CMD_DRAW, '0);
		queue_cmd(CMD_RESEED, 31'h2aaaaaaa);
		queue_cmd(CMD_RESEED, 31'h55555555);
		queue_cmd(CMD_DRAW, 31'h7fffffff);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(99) < 12)
				queue_cmd(CMD_RESEED, pick_seed());
			else
				queue_cmd(CMD_DRAW, VAL_W'($urandom));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || req_ch.valid)
			@(posedge clk);
		while (expected_values.size() > 0)
			@(posedge clk);
		repeat (120) @(posedge clk);

		if (errors == 0)
			$display("PASS combined_lcg_shuffle_rng");
		else
			$display("FAIL combined_lcg_shuffle_rng");
		$finish;
	end

endmodule

@@ combined_lcg_shuffle_rng.f @@
rtl/clsr_pkg.sv
rtl/clsr_if.sv
rtl/clsr_ram.sv
rtl/clsr_modmul.sv
rtl/clsr_ctrl.sv
rtl/clsr_dpath.sv
rtl/combined_lcg_shuffle_rng.sv
tb/sv/tb_combined_lcg_shuffle_rng.sv
